/* hdl/lsb_audio_stego_embed_extract_defines.svh */
// ----------------------------------------------------------------------------
// lsb stego assertion macros
// shared property wrappers, clocked on clock and masked during reset
// ----------------------------------------------------------------------------
`ifndef LSB_AUDIO_STEGO_EMBED_EXTRACT_DEFINES_SVH
`define LSB_AUDIO_STEGO_EMBED_EXTRACT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LSBST_ASSERT_HOLD(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsbst: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LSBST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsbst: next-cycle check failed");

`endif

/* hdl/lsbst_pkg.sv */
// ----------------------------------------------------------------------------
// lsbst_pkg
// shared constants, codes and helper functions for the lsb stego block
// ----------------------------------------------------------------------------
package lsbst_pkg;

   localparam int SAMPLE_W  = 64;
   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 6;
   localparam int BYTES_W   = MAX_BYTES * BYTE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;

   // input word codes
   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // result word codes
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   // direction register codes
   localparam logic DIR_EMBED   = 1'b0;
   localparam logic DIR_EXTRACT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BITS_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_BYTES = 2'd2;

   // bits-per-sample codes
   localparam logic [2:0] MODE_1  = 3'd0;
   localparam logic [2:0] MODE_2  = 3'd1;
   localparam logic [2:0] MODE_4  = 3'd2;
   localparam logic [2:0] MODE_8  = 3'd3;
   localparam logic [2:0] MODE_12 = 3'd4;
   localparam logic [2:0] MODE_16 = 3'd5;
   localparam logic [2:0] MODE_32 = 3'd6;
   localparam logic [2:0] MODE_48 = 3'd7;

   localparam logic [5:0] PAIR_BITS  = 6'd12;
   localparam logic [5:0] PAIR_GROUP = 6'd24;

   typedef logic [5:0] mode_bits_type;

   function automatic mode_bits_type mode_bits(input logic [2:0] code);
      mode_bits_type b;
      case (code)
         MODE_1:  b = 6'd1;
         MODE_2:  b = 6'd2;
         MODE_4:  b = 6'd4;
         MODE_8:  b = 6'd8;
         MODE_12: b = 6'd12;
         MODE_16: b = 6'd16;
         MODE_32: b = 6'd32;
         MODE_48: b = 6'd48;
         default: b = 6'd1;
      endcase
      return b;
   endfunction

   function automatic logic [SAMPLE_W-1:0] lowmask64(input logic [5:0] n);
      return ~({SAMPLE_W{1'b1}} << n);
   endfunction

endpackage

/* hdl/lsbst_if.sv */
// ----------------------------------------------------------------------------
// lsbst channel interfaces
// request channel (payload bytes and samples) and result channel
// ----------------------------------------------------------------------------
interface lsbst_req_if
   import lsbst_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [SAMPLE_W-1:0] sample_in;
   logic [BYTE_W-1:0]   payload_in;

   modport source (output valid, output op, output sample_in, output payload_in,
                   input ready);
   modport sink   (input valid, input op, input sample_in, input payload_in,
                   output ready);
endinterface

interface lsbst_rsp_if
   import lsbst_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SAMPLE_W-1:0] sample_out;
   logic [BYTE_W-1:0]   payload_out;
   logic                untouched;
   logic                last;

   modport source (output valid, output kind, output sample_out, output payload_out,
                   output untouched, output last, input ready);
   modport sink   (input valid, input kind, input sample_out, input payload_out,
                   input untouched, input last, output ready);
endinterface

/* hdl/lsb_audio_stego_embed_extract.sv */
// ----------------------------------------------------------------------------
// lsb_audio_stego_embed_extract
// hides payload bytes in the low bits of audio samples, or recovers them
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per handshake: op 0 pushes payload_in into the
//   bit buffer (embed only, no result), op 1 presents sample_in.
//   rsp_chan returns one modified sample per sample in embed mode, or 0..6
//   extracted bytes per sample in extract mode; last flags the final word
//   caused by a request word.
//   csr_we/csr_index/csr_wdata write direction, bits_mode and sample_bytes;
//   write only while idle. Writing direction or bits_mode clears the buffer.
// Timing:
//   a request word passes the input register, then the result register, before
//   its first result word. One request word is taken per cycle unless results
//   stall; an extracting sample that yields n bytes holds the result register
//   while the single result port drains one byte per cycle, unless stalled.
// Reset:
//   synchronous, active high; buffer, pair phase and both registers stages
//   are cleared, registers return to embed, 1 bit, 2-byte samples.
// Stalls:
//   while rsp_chan.ready is low the result holds, one further request word is
//   kept in the input register and req_chan.ready then drops.
// ----------------------------------------------------------------------------
`include "lsb_audio_stego_embed_extract_defines.svh"

module lsb_audio_stego_embed_extract
   import lsbst_pkg::*;
#(
   parameter int SAMPLE_WIDTH     = 64,
   parameter int MAX_PAYLOAD_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   lsbst_req_if.sink            req_chan,
   lsbst_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int              CW   = $clog2(MAX_PAYLOAD_BITS + 1);
   localparam int              MPB  = MAX_PAYLOAD_BITS;
   localparam logic [6:0]      MPB7 = 7'(MAX_PAYLOAD_BITS);
   localparam logic [6:0]      SW7  = 7'(SAMPLE_WIDTH);
   localparam logic [2:0]      IDXW_MAX = 3'(MAX_BYTES);

   // configuration
   logic                 direction_ff, direction_in;
   logic [2:0]           bits_mode_ff, bits_mode_in;
   logic [3:0]           sample_bytes_ff, sample_bytes_in;

   // stream state
   logic [MPB-1:0]       buf_ff, buf_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   logic [3:0]           nib_ff, nib_in;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 op_ff;
   logic [SAMPLE_W-1:0]  smp_ff;
   logic [BYTE_W-1:0]    pay_ff;

   // result register
   logic                 bun_valid_ff, bun_valid_in;
   logic [2:0]           bun_idx_ff, bun_idx_in;
   logic [2:0]           bun_cnt_ff;
   logic                 bun_kind_ff;
   logic [SAMPLE_W-1:0]  bun_sample_ff;
   logic [BYTES_W-1:0]   bun_bytes_ff;
   logic                 bun_unt_ff;

   // datapath
   mode_bits_type        g;
   logic [6:0]           sbits, cnt7, take_n, shamt, ext_n, ext_sh;
   logic [5:0]           grp;
   logic                 mode_ok, have;
   logic [SAMPLE_W-1:0]  s, placed;
   logic [BYTES_W-1:0]   win;
   logic [MPB-1:0]       rest, ext_buf;
   logic [2:0]           res_n;
   logic                 res_kind, res_unt;
   logic [SAMPLE_W-1:0]  res_sample;
   logic [BYTES_W-1:0]   res_bytes;

   logic                 in_consume, bun_free, rsp_last, cfg_clear, req_fire, rsp_fire;

   function automatic logic [BYTE_W-1:0] req_smp_byte(input logic [SAMPLE_W-1:0] v,
                                                      input int k);
      return v[k*BYTE_W +: BYTE_W];
   endfunction

   assign g     = mode_bits(bits_mode_ff);
   assign sbits = {sample_bytes_ff, 3'b000};
   assign grp   = (g == PAIR_BITS) ? PAIR_GROUP : g;
   assign cnt7  = 7'(cnt_ff);

   assign mode_ok = (sample_bytes_ff != 4'd0) && (sample_bytes_ff <= 4'd8) &&
                    (sbits <= SW7) && ({1'b0, grp} <= MPB7) &&
                    (({g, 1'b0} <= sbits) || ((g == 6'd48) && (sbits >= 7'd64)));

   // keep only the sample's meaningful bytes
   always_comb begin
      for (int k = 0; k < SAMPLE_W / BYTE_W; k++) begin
         s[k*BYTE_W +: BYTE_W] = (4'(k) < sample_bytes_ff) ?
                                 req_smp_byte(smp_ff, k) : '0;
      end
   end

   // embed window: the oldest take_n bits of the buffer
   assign take_n = (g == PAIR_BITS) ? (phase_ff ? 7'd8 : 7'(PAIR_GROUP)) : {1'b0, g};
   assign have   = cnt7 >= take_n;
   assign shamt  = cnt7 - take_n;
   assign win    = BYTES_W'(buf_ff >> shamt);
   assign rest   = buf_ff & ~({MPB{1'b1}} << shamt);

   // oldest byte goes lowest
   always_comb begin
      case (bits_mode_ff)
         MODE_8:  placed = 64'(win[7:0]);
         MODE_16: placed = 64'({win[7:0], win[15:8]});
         MODE_32: placed = 64'({win[7:0], win[15:8], win[23:16], win[31:24]});
         MODE_48: placed = 64'({win[7:0], win[15:8], win[23:16], win[31:24],
                                win[39:32], win[47:40]});
         default: placed = 64'(win) & lowmask64(g);
      endcase
   end

   // extract gather for the 1, 2 and 4 bit modes
   assign ext_n   = cnt7 + {1'b0, g};
   assign ext_buf = (buf_ff << g) | MPB'(s & lowmask64(g));
   assign ext_sh  = ext_n - 7'd8;

   always_comb begin
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      phase_in   = phase_ff;
      nib_in     = nib_ff;
      res_n      = 3'd0;
      res_kind   = KIND_SAMPLE;
      res_unt    = 1'b0;
      res_sample = '0;
      res_bytes  = '0;
      if (op_ff == OP_PUSH) begin
         if (direction_ff == DIR_EMBED && (cnt7 + 7'd8) <= MPB7) begin
            buf_in = (buf_ff << 8) | MPB'(pay_ff);
            cnt_in = cnt_ff + CW'(8);
         end
      end else if (!mode_ok) begin
         res_n      = 3'd1;
         res_sample = s;
         res_unt    = 1'b1;
      end else if (direction_ff == DIR_EMBED) begin
         res_n      = 3'd1;
         res_sample = s;
         res_unt    = 1'b1;
         if (have) begin
            res_unt = 1'b0;
            if (g == PAIR_BITS) begin
               if (!phase_ff) begin
                  // first of pair: low byte, high nibble of third byte; keep second
                  res_sample = {s[SAMPLE_W-1:12], win[7:4], win[23:16]};
                  buf_in     = rest | (MPB'(win[15:8]) << shamt);
                  cnt_in     = cnt_ff - CW'(16);
                  nib_in     = win[3:0];
                  phase_in   = 1'b1;
               end else begin
                  res_sample = {s[SAMPLE_W-1:12], nib_ff, win[7:0]};
                  buf_in     = rest;
                  cnt_in     = cnt_ff - CW'(8);
                  nib_in     = 4'd0;
                  phase_in   = 1'b0;
               end
            end else begin
               res_sample = (s & ~lowmask64(g)) | placed;
               buf_in     = rest;
               cnt_in     = cnt_ff - CW'(take_n);
            end
         end
      end else begin
         res_kind = KIND_BYTE;
         if (g < 6'd8) begin
            if (ext_n >= 7'd8) begin
               res_n              = 3'd1;
               res_bytes[7:0]     = 8'(ext_buf >> ext_sh);
               buf_in             = ext_buf & ~({MPB{1'b1}} << ext_sh);
               cnt_in             = CW'(ext_sh);
            end else begin
               buf_in = ext_buf;
               cnt_in = CW'(ext_n);
            end
         end else if (g == PAIR_BITS) begin
            res_bytes[7:0] = s[7:0];
            if (!phase_ff) begin
               res_n    = 3'd1;
               nib_in   = s[11:8];
               phase_in = 1'b1;
            end else begin
               res_n           = 3'd2;
               res_bytes[15:8] = {nib_ff, s[11:8]};
               nib_in          = 4'd0;
               phase_in        = 1'b0;
            end
         end else begin
            res_n     = 3'(g >> 3);
            res_bytes = s[BYTES_W-1:0];
         end
      end
   end

   // handshakes
   assign rsp_last   = (bun_idx_ff == (bun_cnt_ff - 3'd1));
   assign bun_free   = !bun_valid_ff || (rsp_chan.ready && rsp_last);
   assign in_consume = in_valid_ff && ((res_n == 3'd0) || bun_free);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign cfg_clear  = csr_we && (csr_index == REG_DIRECTION || csr_index == REG_BITS_MODE);

   assign req_chan.ready = !in_valid_ff || in_consume;

   assign rsp_chan.valid       = bun_valid_ff;
   assign rsp_chan.kind        = bun_kind_ff;
   assign rsp_chan.sample_out  = bun_sample_ff;
   assign rsp_chan.payload_out = bun_bytes_ff[{bun_idx_ff, 3'b000} +: BYTE_W];
   assign rsp_chan.untouched   = bun_unt_ff;
   assign rsp_chan.last        = rsp_last;

   always_comb begin
      direction_in    = direction_ff;
      bits_mode_in    = bits_mode_ff;
      sample_bytes_in = sample_bytes_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DIRECTION:    direction_in    = csr_wdata[0];
            REG_BITS_MODE:    bits_mode_in    = csr_wdata[2:0];
            REG_SAMPLE_BYTES: sample_bytes_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      bun_valid_in = bun_valid_ff;
      bun_idx_in   = bun_idx_ff;
      if (in_consume && res_n != 3'd0) begin
         bun_valid_in = 1'b1;
         bun_idx_in   = 3'd0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            bun_valid_in = 1'b0;
         end else begin
            bun_idx_in = bun_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= DIR_EMBED;
         bits_mode_ff    <= MODE_1;
         sample_bytes_ff <= 4'd2;
         buf_ff          <= '0;
         cnt_ff          <= '0;
         phase_ff        <= 1'b0;
         nib_ff          <= 4'd0;
         in_valid_ff     <= 1'b0;
         bun_valid_ff    <= 1'b0;
         bun_idx_ff      <= 3'd0;
      end else begin
         direction_ff    <= direction_in;
         bits_mode_ff    <= bits_mode_in;
         sample_bytes_ff <= sample_bytes_in;
         in_valid_ff     <= in_valid_in;
         bun_valid_ff    <= bun_valid_in;
         bun_idx_ff      <= bun_idx_in;
         if (cfg_clear) begin
            buf_ff   <= '0;
            cnt_ff   <= '0;
            phase_ff <= 1'b0;
            nib_ff   <= 4'd0;
         end else if (in_consume) begin
            buf_ff   <= buf_in;
            cnt_ff   <= cnt_in;
            phase_ff <= phase_in;
            nib_ff   <= nib_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_chan.op;
         smp_ff <= req_chan.sample_in;
         pay_ff <= req_chan.payload_in;
      end
      if (in_consume && res_n != 3'd0) begin
         bun_cnt_ff    <= res_n;
         bun_kind_ff   <= res_kind;
         bun_sample_ff <= res_sample;
         bun_bytes_ff  <= res_bytes;
         bun_unt_ff    <= res_unt;
      end
   end

   `LSBST_ASSERT_HOLD(a_bun_count, bun_valid_ff, bun_cnt_ff != 3'd0 && bun_cnt_ff <= IDXW_MAX)
   `LSBST_ASSERT_HOLD(a_bun_index, bun_valid_ff, bun_idx_ff < bun_cnt_ff)
   `LSBST_ASSERT_HOLD(a_fill_bound, 1'b1, cnt7 <= MPB7)
   `LSBST_ASSERT_HOLD(a_byte_clean, rsp_chan.valid && rsp_chan.kind == KIND_BYTE,
                      !rsp_chan.untouched && rsp_chan.sample_out == '0)
   `LSBST_ASSERT_NEXT(a_cfg_clear, cfg_clear, cnt_ff == '0 && !phase_ff && nib_ff == 4'd0)

endmodule
